// ===== rtl/qrm_pkg.sv =====
// Shared types and constants for the quaternion to rotation matrix core.
// Used by every module in rtl/.
`default_nettype none
package qrm_pkg;

    localparam int COMP_W = 16;
    localparam int TOL_W  = 26;
    localparam int SUM_W  = 33;
    localparam int ROOT_W = 17;
    localparam int REM_W  = 20;

    localparam logic [TOL_W-1:0]  TOL_RESET = 26'd671;
    localparam logic [COMP_W-1:0] SAT_POS   = 16'h7fff;
    localparam logic [COMP_W-1:0] SAT_NEG   = 16'h8000;

    typedef logic [3:0][COMP_W-1:0] quat_t;

    typedef struct packed {
        quat_t             comp;
        logic              zero;
        logic              far;
        logic [ROOT_W-1:0] root;
    } sqrt_beat_t;

endpackage
`default_nettype wire

// ===== rtl/quaternion_to_rotation_matrix_core.sv =====
// Top level of the quaternion to 3x3 rotation matrix core.
// Depends on qrm_pkg, qrm_sqrt, qrm_div and qrm_matrix.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one quaternion per beat,
//   quat_w..quat_z in signed Q2.F. Output channel (out_valid/out_ready)
//   carries the nine matrix entries m_r_c and zero_error per beat.
//   cfg_we writes norm_tolerance from cfg_wdata; write it only
//   while no beat is in flight.
// Pipeline: squares, sum and tolerance test stages, 17 root stages,
//   FRAC_BITS + 2 divider stages, 3 matrix stages.
// Throughput: one beat per cycle while the output is not stalled; every
//   stage holds its own valid bit.
// Stall: when out_ready is low, stages fill up back to front; in_ready
//   drops only once the stage behind the input is full, so bubbles collapse
//   and nothing is dropped or repeated.
// Reset: rst_n clears all valid bits and restores norm_tolerance to 671.
// An all-zero quaternion gives zero entries with zero_error set.
`default_nettype none
module quaternion_to_rotation_matrix_core
    import qrm_pkg::*;
#(
    parameter int FRAC_BITS = 13
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] quat_w,
    input  wire logic signed [15:0] quat_x,
    input  wire logic signed [15:0] quat_y,
    input  wire logic signed [15:0] quat_z,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      m_0_0,
    output logic signed [15:0]      m_1_0,
    output logic signed [15:0]      m_2_0,
    output logic signed [15:0]      m_0_1,
    output logic signed [15:0]      m_1_1,
    output logic signed [15:0]      m_2_1,
    output logic signed [15:0]      m_0_2,
    output logic signed [15:0]      m_1_2,
    output logic signed [15:0]      m_2_2,
    output logic                    zero_error,
    input  wire logic               cfg_we,
    input  wire logic [TOL_W-1:0]   cfg_wdata
);

    // Normalized components reach 2^F, so they need F+2 bits signed.
    localparam int CW = (FRAC_BITS + 2 > COMP_W) ? FRAC_BITS + 2 : COMP_W;

    logic [TOL_W-1:0]       tol_reg;
    quat_t                  quat;
    sqrt_beat_t             sq_data;
    logic                   sq_valid, sq_ready;
    logic [3:0][CW-1:0]     nc;
    logic                   nz;
    logic                   dv_valid, dv_ready;
    logic [8:0][COMP_W-1:0] entry;

    // Hold the tolerance; cfg_we writes it from cfg_wdata.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= TOL_RESET;
        else if (cfg_we)
            tol_reg <= cfg_wdata;
    end

    assign quat = {quat_z, quat_y, quat_x, quat_w};

    qrm_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .comp_in   (quat),
        .tol       (tol_reg),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .out_data  (sq_data)
    );

    qrm_div #(.FRAC_BITS(FRAC_BITS), .CW(CW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_ready  (sq_ready),
        .in_data   (sq_data),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .comp_out  (nc),
        .zero_out  (nz)
    );

    qrm_matrix #(.FRAC_BITS(FRAC_BITS), .CW(CW)) u_matrix (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (dv_valid),
        .in_ready   (dv_ready),
        .comp_in    (nc),
        .zero_in    (nz),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .entry      (entry),
        .zero_error (zero_error)
    );

    assign m_0_0 = entry[0];
    assign m_1_0 = entry[1];
    assign m_2_0 = entry[2];
    assign m_0_1 = entry[3];
    assign m_1_1 = entry[4];
    assign m_2_1 = entry[5];
    assign m_0_2 = entry[6];
    assign m_1_2 = entry[7];
    assign m_2_2 = entry[8];

`ifndef SYNTHESIS
    a_zero_entries: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_error |-> m_0_0 == 0 && m_1_1 == 0 && m_2_2 == 0
                                    && m_1_0 == 0 && m_0_1 == 0)
        else $error("zero quaternion gave nonzero entries");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with an empty output stage");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> tol_reg == $past(cfg_wdata))
        else $error("tolerance write lost");
`endif

endmodule
`default_nettype wire

// ===== rtl/qrm_sqrt.sv =====
// Sum of squares, tolerance test and pipelined integer square root.
// Depends on qrm_pkg.
`default_nettype none
module qrm_sqrt
    import qrm_pkg::*;
#(
    parameter int FRAC_BITS = 13
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire quat_t            comp_in,
    input  wire logic [TOL_W-1:0] tol,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output sqrt_beat_t            out_data
);

    localparam int N     = 3 + ROOT_W;
    localparam int TWO_F = 2 * FRAC_BITS;
    localparam int DW    = ((TWO_F > SUM_W) ? TWO_F : SUM_W) + 1;
    localparam int CMPW  = DW + TOL_W;
    localparam int LSH   = (TWO_F >= TOL_W) ? 0 : TOL_W - TWO_F;
    localparam int RSH   = (TWO_F >= TOL_W) ? TWO_F - TOL_W : 0;
    localparam logic [DW-1:0] ONE_V = {{(DW-1){1'b0}}, 1'b1} << TWO_F;

    logic [N-1:0]          v_reg;
    logic [N:0]            rdy;
    quat_t                 comp_reg [N];
    logic                  zero_reg [N];
    logic [3:0][30:0]      sq_reg;
    logic [SUM_W-1:0]      sum_reg  [1:N-1];
    logic                  far_reg  [2:N-1];
    logic [REM_W-1:0]      rem_reg  [ROOT_W];
    logic [ROOT_W-1:0]     root_reg [ROOT_W];

    logic [DW-1:0]         sum_ext;
    logic [DW-1:0]         dev;
    logic                  far_next;

    assign rdy[N]    = out_ready;
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[N-1];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_vld
            assign rdy[k] = !v_reg[k] || rdy[k+1];
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[k] <= 1'b0;
                else if (rdy[k])
                    v_reg[k] <= (k == 0) ? in_valid : v_reg[(k == 0) ? 0 : k-1];
            end
        end
    endgenerate

    // Stage 0: squares of the four components.
    always_ff @(posedge clk)
    begin
        if (rdy[0] && in_valid)
        begin
            for (int l = 0; l < 4; l++)
                sq_reg[l] <= 31'($signed(comp_in[l]) * $signed(comp_in[l]));
            comp_reg[0] <= comp_in;
            zero_reg[0] <= (comp_in == '0);
        end
    end

    // Stage 1: sum of squares.
    always_ff @(posedge clk)
    begin
        if (rdy[1] && v_reg[0])
        begin
            sum_reg[1]  <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1])
                         + SUM_W'(sq_reg[2]) + SUM_W'(sq_reg[3]);
            comp_reg[1] <= comp_reg[0];
            zero_reg[1] <= zero_reg[0];
        end
    end

    // Stage 2: distance of the squared length from one against tolerance.
    always_comb
    begin
        sum_ext  = DW'(sum_reg[1]);
        dev      = (sum_ext > ONE_V) ? sum_ext - ONE_V : ONE_V - sum_ext;
        far_next = (CMPW'(dev) << LSH) > (CMPW'(tol) << RSH);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[2] && v_reg[1])
        begin
            sum_reg[2]  <= sum_reg[1];
            far_reg[2]  <= far_next;
            comp_reg[2] <= comp_reg[1];
            zero_reg[2] <= zero_reg[1];
        end
    end

    // Root stages: one result bit each, two radicand bits brought down.
    genvar j;
    generate
        for (j = 0; j < ROOT_W; j++) begin : g_root
            localparam int K = 3 + j;
            logic [REM_W-1:0]  rem_in;
            logic [ROOT_W-1:0] root_in;
            logic [SUM_W:0]    s_pad;
            logic [REM_W+1:0]  trial;
            logic [REM_W+1:0]  sub;

            if (j == 0) begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
            end else begin : g_next
                assign rem_in  = rem_reg[j-1];
                assign root_in = root_reg[j-1];
            end

            assign s_pad = {1'b0, sum_reg[K-1]};
            assign trial = {rem_in, s_pad[2*(ROOT_W-1-j)+1 -: 2]};
            assign sub   = (REM_W+2)'({root_in, 2'b01});

            always_ff @(posedge clk)
            begin
                if (rdy[K] && v_reg[K-1])
                begin
                    if (trial >= sub)
                    begin
                        rem_reg[j]  <= REM_W'(trial - sub);
                        root_reg[j] <= {root_in[ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[j]  <= REM_W'(trial);
                        root_reg[j] <= {root_in[ROOT_W-2:0], 1'b0};
                    end
                    sum_reg[K]  <= sum_reg[K-1];
                    far_reg[K]  <= far_reg[K-1];
                    comp_reg[K] <= comp_reg[K-1];
                    zero_reg[K] <= zero_reg[K-1];
                end
            end
        end
    endgenerate

    assign out_data.comp = comp_reg[N-1];
    assign out_data.zero = zero_reg[N-1];
    assign out_data.far  = far_reg[N-1];
    assign out_data.root = root_reg[ROOT_W-1];

endmodule
`default_nettype wire

// ===== rtl/qrm_div.sv =====
// Four-lane pipelined restoring divider: component * 2^F / root.
// Depends on qrm_pkg.
`default_nettype none
module qrm_div
    import qrm_pkg::*;
#(
    parameter int FRAC_BITS = 13,
    parameter int CW        = 16
)(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire sqrt_beat_t          in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [3:0][CW-1:0]       comp_out,
    output logic                     zero_out
);

    localparam int Q = FRAC_BITS + 1;
    localparam int N = Q + 1;
    localparam int RW = ROOT_W;

    logic [N-1:0]          v_reg;
    logic [N:0]            rdy;
    quat_t                 comp_reg [N];
    logic                  zero_reg [N];
    logic                  far_reg  [N];
    logic [ROOT_W-1:0]     root_reg [Q];
    logic [3:0][RW-1:0]    rem_reg  [Q];
    logic [3:0][Q-1:0]     q_reg    [Q];
    logic [3:0][CW-1:0]    res_reg;

    assign rdy[N]    = out_ready;
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[N-1];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_vld
            assign rdy[k] = !v_reg[k] || rdy[k+1];
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[k] <= 1'b0;
                else if (rdy[k])
                    v_reg[k] <= (k == 0) ? in_valid : v_reg[(k == 0) ? 0 : k-1];
            end
        end
    endgenerate

    genvar i, l;
    generate
        for (i = 0; i < Q; i++) begin : g_step
            quat_t             c_in;
            logic              z_in;
            logic              f_in;
            logic              vin;
            logic [ROOT_W-1:0] r_in;
            logic [3:0][RW-1:0] rem_in;
            logic [3:0][Q-1:0]  q_in;
            logic [3:0]         bit_in;

            if (i == 0) begin : g_first
                assign c_in = in_data.comp;
                assign z_in = in_data.zero;
                assign f_in = in_data.far;
                assign r_in = in_data.root;
                assign vin  = in_valid;
                for (l = 0; l < 4; l++) begin : g_lane0
                    logic [COMP_W-1:0] mag;
                    assign mag       = in_data.comp[l][COMP_W-1]
                                     ? COMP_W'(-in_data.comp[l]) : in_data.comp[l];
                    assign rem_in[l] = RW'(mag[COMP_W-1:1]);
                    assign bit_in[l] = mag[0];
                    assign q_in[l]   = '0;
                end
            end else begin : g_next
                assign c_in   = comp_reg[i-1];
                assign z_in   = zero_reg[i-1];
                assign f_in   = far_reg[i-1];
                assign r_in   = root_reg[i-1];
                assign vin    = v_reg[i-1];
                assign rem_in = rem_reg[i-1];
                assign q_in   = q_reg[i-1];
                assign bit_in = '0;
            end

            for (l = 0; l < 4; l++) begin : g_lane
                logic [RW:0] trial;
                logic        take;
                assign trial = {rem_in[l], bit_in[l]};
                assign take  = trial >= (RW+1)'(r_in);

                always_ff @(posedge clk)
                begin
                    if (rdy[i] && vin)
                    begin
                        rem_reg[i][l] <= take ? RW'(trial - (RW+1)'(r_in)) : RW'(trial);
                        q_reg[i][l]   <= {q_in[l][Q-2:0], take};
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[i] && vin)
                begin
                    comp_reg[i] <= c_in;
                    zero_reg[i] <= z_in;
                    far_reg[i]  <= f_in;
                    root_reg[i] <= r_in;
                end
            end
        end
    endgenerate

    // Last stage: apply sign, or keep the raw component when in tolerance.
    always_ff @(posedge clk)
    begin
        if (rdy[Q] && v_reg[Q-1])
        begin
            for (int m = 0; m < 4; m++)
            begin
                if (!far_reg[Q-1])
                    res_reg[m] <= CW'($signed(comp_reg[Q-1][m]));
                else if (comp_reg[Q-1][m][COMP_W-1])
                    res_reg[m] <= CW'(0) - CW'(q_reg[Q-1][m]);
                else
                    res_reg[m] <= CW'(q_reg[Q-1][m]);
            end
            zero_reg[Q] <= zero_reg[Q-1];
            far_reg[Q]  <= far_reg[Q-1];
            comp_reg[Q] <= comp_reg[Q-1];
        end
    end

    assign comp_out = res_reg;
    assign zero_out = zero_reg[Q] && (comp_reg[Q] == '0) && (far_reg[Q] || !far_reg[Q]);

endmodule
`default_nettype wire

// ===== rtl/qrm_matrix.sv =====
// Products, matrix entry sums and Q2.F saturation, three stages.
// Depends on qrm_pkg.
`default_nettype none
module qrm_matrix
    import qrm_pkg::*;
#(
    parameter int FRAC_BITS = 13,
    parameter int CW        = 16
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [3:0][CW-1:0] comp_in,
    input  wire logic             zero_in,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [8:0][COMP_W-1:0] entry,
    output logic                  zero_error
);

    localparam int N  = 3;
    localparam int PW = 2 * CW;
    localparam int EW = PW + 3;
    localparam logic signed [EW-1:0] ONE_E = EW'(1) <<< (2 * FRAC_BITS);

    logic [N-1:0] v_reg;
    logic [N:0]   rdy;
    logic         zero_reg [N];
    logic signed [PW-1:0] p_reg [9];
    logic signed [EW-1:0] e_reg [9];
    logic [8:0][COMP_W-1:0] out_reg;

    logic signed [CW-1:0] w, x, y, z;
    logic signed [EW-1:0] pe [9];

    assign rdy[N]    = out_ready;
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[N-1];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_vld
            assign rdy[k] = !v_reg[k] || rdy[k+1];
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[k] <= 1'b0;
                else if (rdy[k])
                    v_reg[k] <= (k == 0) ? in_valid : v_reg[(k == 0) ? 0 : k-1];
            end
        end
    endgenerate

    function automatic logic [COMP_W-1:0] sat_out(input logic signed [EW-1:0] e);
        logic [EW-1:0] mag;
        logic [EW-1:0] sh;
        mag = e[EW-1] ? EW'(-e) : EW'(e);
        sh  = mag >> FRAC_BITS;
        if (!e[EW-1])
            return (sh > EW'(32767)) ? SAT_POS : sh[COMP_W-1:0];
        else
            return (sh >= EW'(32768)) ? SAT_NEG : COMP_W'(~sh[COMP_W-1:0] + 1'b1);
    endfunction

    assign w = $signed(comp_in[0]);
    assign x = $signed(comp_in[1]);
    assign y = $signed(comp_in[2]);
    assign z = $signed(comp_in[3]);

    // Products: 0 xx, 1 yy, 2 zz, 3 xy, 4 xz, 5 yz, 6 wx, 7 wy, 8 wz.
    always_ff @(posedge clk)
    begin
        if (rdy[0] && in_valid)
        begin
            p_reg[0]    <= x * x;
            p_reg[1]    <= y * y;
            p_reg[2]    <= z * z;
            p_reg[3]    <= x * y;
            p_reg[4]    <= x * z;
            p_reg[5]    <= y * z;
            p_reg[6]    <= w * x;
            p_reg[7]    <= w * y;
            p_reg[8]    <= w * z;
            zero_reg[0] <= zero_in;
        end
    end

    always_comb
    begin
        for (int m = 0; m < 9; m++)
            pe[m] = EW'(p_reg[m]) <<< 1;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1] && v_reg[0])
        begin
            e_reg[0]    <= ONE_E - pe[1] - pe[2];
            e_reg[1]    <= pe[3] - pe[8];
            e_reg[2]    <= pe[4] + pe[7];
            e_reg[3]    <= pe[3] + pe[8];
            e_reg[4]    <= ONE_E - pe[0] - pe[2];
            e_reg[5]    <= pe[5] - pe[6];
            e_reg[6]    <= pe[4] - pe[7];
            e_reg[7]    <= pe[5] + pe[6];
            e_reg[8]    <= ONE_E - pe[0] - pe[1];
            zero_reg[1] <= zero_reg[0];
        end
    end

    // Truncate toward zero, clamp; force zero entries on an all-zero input.
    always_ff @(posedge clk)
    begin
        if (rdy[2] && v_reg[1])
        begin
            for (int m = 0; m < 9; m++)
                out_reg[m] <= zero_reg[1] ? '0 : sat_out(e_reg[m]);
            zero_reg[2] <= zero_reg[1];
        end
    end

    assign entry      = out_reg;
    assign zero_error = zero_reg[2];

endmodule
`default_nettype wire
